### hdl/rqc_pkg.sv
// Package: shared types, constants and command/status structs for the quad clipper.
`timescale 1ns / 1ps
`default_nettype none
package rqc_pkg;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned HalfWidth  = 31;
  localparam int unsigned MaxPts     = 8;
  localparam int unsigned QuadPts    = 4;
  localparam int unsigned IdxWidth   = 3;
  localparam int unsigned CntWidth   = 4;
  localparam int unsigned DivWidth   = 64;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [IdxWidth-1:0] idx_t;
  typedef logic [CntWidth-1:0] cnt_t;

  // Controller-to-datapath commands.
  typedef struct packed {
    logic load;       // take a new input beat into the point list
    logic eval;       // latch current and next point of edge cur_idx
    logic keep_cur;   // append current point to the result list
    logic div_start;  // begin the crossing division
    logic keep_cross; // append the crossing point
    logic commit;     // copy result list to point list
    logic emit_load;  // load output register with point emit_idx
    idx_t cur_idx;
    idx_t emit_idx;
    logic dir;        // 0: x axis, 1: y axis
    logic side;       // 0: lower line, 1: upper line
  } rqc_cmd_t;

  // Datapath-to-controller status.
  typedef struct packed {
    logic in_cur;
    logic in_nxt;
    logic div_done;
    cnt_t nq;
    cnt_t nr;
  } rqc_sts_t;
endpackage
`default_nettype wire

### hdl/rqc_div.sv
// Sequential unsigned divider, one quotient bit per cycle (128 / 64 bits).
`timescale 1ns / 1ps
`default_nettype none
module rqc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [2*rqc_pkg::DivWidth-1:0] num_i,
  input  wire logic [rqc_pkg::DivWidth-1:0] den_i,
  output logic                              done_o,
  output logic [rqc_pkg::DivWidth-1:0]      quo_o
);
  localparam int unsigned W = rqc_pkg::DivWidth;
  logic [2*W-1:0] num_q, num_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   den_q, quo_q, quo_d;
  logic [7:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;
  logic [W:0]     shifted;

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[W-1:0], num_q[2*W-1]};
    if (start_i) begin
      num_d = num_i; rem_d = '0; quo_d = '0; cnt_d = 8'd128; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[2*W-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 8'd1;
      if (cnt_q == 8'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
endmodule
`default_nettype wire

### hdl/rqc_datapath.sv
// Datapath: point lists, inside tests, crossing arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none
module rqc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rqc_pkg::rqc_cmd_t            cmd_i,
  output rqc_pkg::rqc_sts_t                 sts_o,
  input  wire logic [rqc_pkg::HalfWidth-1:0] half_x_i,
  input  wire logic [rqc_pkg::HalfWidth-1:0] half_y_i,
  input  wire rqc_pkg::coord_t              vx_i [rqc_pkg::QuadPts],
  input  wire rqc_pkg::coord_t              vy_i [rqc_pkg::QuadPts],
  output rqc_pkg::coord_t                   pt_x_o,
  output rqc_pkg::coord_t                   pt_y_o
);
  localparam int unsigned W = rqc_pkg::DivWidth;
  rqc_pkg::coord_t qx_q [rqc_pkg::MaxPts];
  rqc_pkg::coord_t qy_q [rqc_pkg::MaxPts];
  rqc_pkg::coord_t rx_q [rqc_pkg::MaxPts];
  rqc_pkg::coord_t ry_q [rqc_pkg::MaxPts];
  logic [rqc_pkg::HalfWidth-1:0] hx_q, hy_q;
  rqc_pkg::cnt_t nq_q, nr_q;
  rqc_pkg::coord_t cx_q, cy_q, nx_q, ny_q;
  logic signed [33:0] line_q;
  logic neg_q, zero_q;
  logic signed [33:0] a_q, b_q, d_q;
  logic [67:0] prod_q;
  logic [33:0] mag_d_q;
  rqc_pkg::coord_t px_q, py_q;
  logic div_done;
  logic [W-1:0] quo;

  // Edge selection and inside tests.
  rqc_pkg::idx_t nidx;
  logic signed [33:0] half_s, line_s, cax, nax, cot, not_;
  logic in_c, in_n;
  always_comb begin
    nidx = (({1'b0, cmd_i.cur_idx} + 4'd1) == nq_q) ? '0 : cmd_i.cur_idx + 3'd1;
    half_s = cmd_i.dir ? {3'b0, hy_q} : {3'b0, hx_q};
    line_s = cmd_i.side ? half_s : -half_s;
    cax = cmd_i.dir ? 34'(cy_q) : 34'(cx_q);
    nax = cmd_i.dir ? 34'(ny_q) : 34'(nx_q);
    cot = cmd_i.dir ? 34'(cx_q) : 34'(cy_q);
    not_ = cmd_i.dir ? 34'(nx_q) : 34'(ny_q);
    in_c = cmd_i.side ? (cax < half_s) : (-cax < half_s);
    in_n = cmd_i.side ? (nax < half_s) : (-nax < half_s);
  end

  // Magnitudes of the crossing operands.
  logic [33:0] ma, mb;
  assign ma = a_q[33] ? 34'(-a_q) : 34'(a_q);
  assign mb = b_q[33] ? 34'(-b_q) : 34'(b_q);

  // Full product from a 32 x 32 core and two narrow partial products.
  logic [63:0] prod_ll;
  logic [35:0] prod_hl;
  logic [33:0] prod_lh;
  assign prod_ll = ma[31:0] * mb[31:0];
  assign prod_hl = ma[33:32] * mb;
  assign prod_lh = ma[31:0] * mb[33:32];

  rqc_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i  ({60'd0, prod_q}),
    .den_i  ({30'd0, mag_d_q}),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic signed [33:0] tval, cross_o;
  assign tval = (zero_q) ? '0 : (neg_q ? -34'(quo[33:0]) : 34'(quo[33:0]));
  assign cross_o = cot + tval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q <= '0; nr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        nq_q <= rqc_pkg::cnt_t'(rqc_pkg::QuadPts); nr_q <= '0;
      end
      if (cmd_i.keep_cur || cmd_i.keep_cross) nr_q <= nr_q + 4'd1;
      if (cmd_i.commit) begin
        nq_q <= nr_q; nr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hx_q <= half_x_i; hy_q <= half_y_i;
      for (int i = 0; i < rqc_pkg::QuadPts; i++) begin
        qx_q[i] <= vx_i[i]; qy_q[i] <= vy_i[i];
      end
    end
    if (cmd_i.eval) begin
      cx_q <= qx_q[cmd_i.cur_idx]; cy_q <= qy_q[cmd_i.cur_idx];
      nx_q <= qx_q[nidx];          ny_q <= qy_q[nidx];
    end
    // Operands are registered in the cycle after eval, the product in the cycle after that.
    a_q <= not_ - cot;
    b_q <= line_s - cax;
    d_q <= nax - cax;
    line_q <= line_s;
    neg_q <= a_q[33] ^ b_q[33] ^ d_q[33];
    zero_q <= (a_q == '0) || (b_q == '0);
    prod_q <= {4'd0, prod_ll} + {prod_hl, 32'd0} + {2'd0, prod_lh, 32'd0};
    mag_d_q <= d_q[33] ? 34'(-d_q) : 34'(d_q);
    if (cmd_i.keep_cur) begin
      rx_q[nr_q[2:0]] <= cx_q; ry_q[nr_q[2:0]] <= cy_q;
    end
    if (cmd_i.keep_cross) begin
      if (cmd_i.dir) begin
        rx_q[nr_q[2:0]] <= cross_o[31:0]; ry_q[nr_q[2:0]] <= line_q[31:0];
      end else begin
        rx_q[nr_q[2:0]] <= line_q[31:0]; ry_q[nr_q[2:0]] <= cross_o[31:0];
      end
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < rqc_pkg::MaxPts; i++) begin
        qx_q[i] <= rx_q[i]; qy_q[i] <= ry_q[i];
      end
    end
    if (cmd_i.emit_load) begin
      px_q <= qx_q[cmd_i.emit_idx]; py_q <= qy_q[cmd_i.emit_idx];
    end
  end

  assign sts_o.in_cur   = in_c;
  assign sts_o.in_nxt   = in_n;
  assign sts_o.div_done = div_done;
  assign sts_o.nq       = nq_q;
  assign sts_o.nr       = nr_q;
  assign pt_x_o = px_q;
  assign pt_y_o = py_q;

  a_nr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nr_q <= 4'd8) else $error("result list overflow");
  a_nq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nq_q <= 4'd8) else $error("point list overflow");
  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> nr_q == '0) else $error("result count not cleared");
endmodule
`default_nettype wire

### hdl/rqc_ctrl.sv
// Controller: sequences passes, edges, divisions and output beats.
`timescale 1ns / 1ps
`default_nettype none
module rqc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rqc_pkg::rqc_cmd_t      cmd_o,
  input  wire rqc_pkg::rqc_sts_t sts_i,
  output rqc_pkg::idx_t          out_index_o,
  output rqc_pkg::cnt_t          out_count_o,
  output logic                   out_pvalid_o,
  output logic                   out_last_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EVAL  = 9'b000000010,
    S_OPS   = 9'b000000100,
    S_PROD  = 9'b000001000,
    S_TEST  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  rqc_pkg::idx_t cur_q, cur_d, emit_q, emit_d;
  logic [1:0] pass_q, pass_d;
  logic ov_valid_q, ov_valid_d;
  rqc_pkg::cnt_t cnt_q, cnt_d;
  logic pv_q, pv_d, last_q, last_d;
  rqc_pkg::idx_t idx_q, idx_d;

  always_comb begin
    state_d = state_q; cur_d = cur_q; emit_d = emit_q; pass_d = pass_q;
    ov_valid_d = ov_valid_q; cnt_d = cnt_q;
    pv_d = pv_q; last_d = last_q; idx_d = idx_q;
    cmd_o = '0;
    cmd_o.cur_idx = cur_q; cmd_o.emit_idx = emit_q;
    cmd_o.dir = pass_q[1]; cmd_o.side = pass_q[0];
    in_ready_o = 1'b0;
    if (ov_valid_q && out_ready_i) ov_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; cur_d = '0; pass_d = '0; state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.nq == '0) begin
          state_d = S_EMIT; emit_d = '0;
        end else begin
          cmd_o.eval = 1'b1; state_d = S_OPS;
        end
      end
      S_OPS:  state_d = S_PROD;
      S_PROD: state_d = S_TEST;
      S_TEST: begin
        if (sts_i.in_cur) begin
          cmd_o.keep_cur = 1'b1;
          if (sts_i.nr == 4'd7) begin
            state_d = S_EMIT; emit_d = '0; cmd_o.commit = 1'b0;
          end
        end
        if (!(sts_i.in_cur && sts_i.nr == 4'd7)) begin
          if (sts_i.in_cur != sts_i.in_nxt) begin
            cmd_o.div_start = 1'b1; state_d = S_DIV;
          end else begin
            state_d = S_NEXT;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.keep_cross = 1'b1;
          state_d = (sts_i.nr == 4'd7) ? S_EMIT : S_NEXT;
          emit_d = '0;
        end
      end
      S_NEXT: begin
        if ({1'b0, cur_q} + 4'd1 == sts_i.nq) begin
          cmd_o.commit = 1'b1; cur_d = '0;
          if (pass_q == 2'd3) begin
            state_d = S_EMIT; emit_d = '0;
          end else begin
            pass_d = pass_q + 2'd1; state_d = S_EVAL;
          end
        end else begin
          cur_d = cur_q + 3'd1; state_d = S_EVAL;
        end
      end
      S_EMIT: begin
        // Early stop leaves eight points in the result list; move them over.
        if (sts_i.nr == 4'd8) cmd_o.commit = 1'b1;
        else if (!ov_valid_d) begin
          cmd_o.emit_load = 1'b1;
          ov_valid_d = 1'b1;
          cnt_d = sts_i.nq; idx_d = emit_q;
          pv_d = sts_i.nq != '0;
          last_d = (sts_i.nq == '0) || ({1'b0, emit_q} + 4'd1 == sts_i.nq);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (ov_valid_q && out_ready_i) begin
          if (last_q) state_d = S_IDLE;
          else begin
            emit_d = emit_q + 3'd1; state_d = S_EMIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cur_q <= '0; emit_q <= '0; pass_q <= '0;
      ov_valid_q <= 1'b0; cnt_q <= '0;
      pv_q <= 1'b0; last_q <= 1'b0; idx_q <= '0;
    end else begin
      state_q <= state_d; cur_q <= cur_d; emit_q <= emit_d; pass_q <= pass_d;
      ov_valid_q <= ov_valid_d; cnt_q <= cnt_d;
      pv_q <= pv_d; last_q <= last_d; idx_q <= idx_d;
    end
  end

  assign out_valid_o  = ov_valid_q;
  assign out_index_o  = pv_q ? idx_q : '0;
  assign out_count_o  = cnt_q;
  assign out_pvalid_o = pv_q;
  assign out_last_o   = last_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ov_valid_q || out_ready_i || state_q == S_IDLE)
    else $error("ready outside idle");
  a_valid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_valid_q |-> state_q == S_OUT) else $error("output valid outside emit");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_valid_q && !pv_q) |-> last_q) else $error("empty result not last");
endmodule
`default_nettype wire

### hdl/rect_quad_clip_top.sv
// Top level: clips a quad against a centered rectangle, streams points out.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Slave channel s_axis_* takes one beat per quad: half sizes and four vertices.
//  Master channel m_axis_* gives one beat per surviving point, in polygon order,
//  with tlast on the final point. An empty polygon gives one beat with
//  point_valid low and coordinates zero.
//  The quad is clipped in four passes (x low, x high, y low, y high). Each
//  edge steps through the states eval, ops, prod, test and next; each
//  crossing adds a bit-serial division, so the shared divider sets the pace.
//  Clipping stops once eight points are collected.
//  One quad is handled at a time: s_axis_tready is high only while idle.
//  When the receiver stalls, hold the output beat in its register until it is
//  taken; the controller waits. Reset returns to idle with no beat pending.
module rect_quad_clip_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: half_x[30:0], half_y[61:31], v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
  //        v3_x, v3_y (32 bits each from bit 62), zero fill to 320 bits
  input  wire logic [319:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: point_x[31:0], point_y[63:32], point_index[66:64],
  //        point_count[70:67], point_valid[71]
  output logic [71:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  rqc_pkg::rqc_cmd_t cmd;
  rqc_pkg::rqc_sts_t sts;
  rqc_pkg::coord_t vx [rqc_pkg::QuadPts];
  rqc_pkg::coord_t vy [rqc_pkg::QuadPts];
  rqc_pkg::coord_t px, py;
  rqc_pkg::idx_t oidx;
  rqc_pkg::cnt_t ocnt;
  logic opv;

  always_comb begin
    for (int i = 0; i < rqc_pkg::QuadPts; i++) begin
      vx[i] = s_axis_tdata[62 + 64*i +: 32];
      vy[i] = s_axis_tdata[94 + 64*i +: 32];
    end
  end

  rqc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .out_index_o (oidx),
    .out_count_o (ocnt),
    .out_pvalid_o(opv),
    .out_last_o  (m_axis_tlast)
  );

  rqc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i   (cmd),
    .sts_o   (sts),
    .half_x_i(s_axis_tdata[30:0]),
    .half_y_i(s_axis_tdata[61:31]),
    .vx_i    (vx),
    .vy_i    (vy),
    .pt_x_o  (px),
    .pt_y_o  (py)
  );

  // Zero the coordinates on an empty result.
  assign m_axis_tdata = {opv, ocnt, oidx, opv ? py : 32'd0, opv ? px : 32'd0};
endmodule
`default_nettype wire
